### sv/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Types, codes and colour helpers for the TIM pixel decoder.
// ----------------------------------------------------------------------------
package tpd_pkg;

  localparam int MAX_HEIGHT = 512;
  localparam logic [4:0] C5_MASK = 5'h1F;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  typedef enum logic {
    CMD_PALETTE = 1'b0,
    CMD_DATA    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_4BPP  = 2'd0,
    MODE_8BPP  = 2'd1,
    MODE_16BPP = 2'd2,
    MODE_24BPP = 2'd3
  } pix_mode_t;

  localparam logic [1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

  typedef struct packed {
    cmd_t        command;
    logic [7:0]  palette_index;
    logic [15:0] palette_word;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
    logic       end_of_image;
  } out_item_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [4:0] m;
    m = v & C5_MASK;
    return {m, m[4:2]};
  endfunction

  // BGR555 word to pixel, flags clear
  function automatic out_item_t bgr555_pixel(input logic [15:0] c);
    out_item_t p;
    p.red          = widen5(c[4:0]);
    p.green        = widen5(c[9:5]);
    p.blue         = widen5(c[14:10]);
    p.alpha        = c[15] ? ALPHA_OPAQUE : 8'd0;
    p.last_of_run  = 1'b0;
    p.end_of_image = 1'b0;
    return p;
  endfunction

endpackage

### sv/tpd_ram.sv
// ----------------------------------------------------------------------------
// tpd_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tpd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### sv/tim_pixel_decoder_to_rgba_core.sv
// ----------------------------------------------------------------------------
// tim_pixel_decoder_to_rgba_core
// Decodes a TIM pixel byte stream (4/8/16/24 bpp) into RGBA pixels, with a
// palette held in a RAM.
//
//   channel  ports                                  moves
//   in       in_valid in_ready in_data              palette write or data byte
//   out      out_valid out_ready out_data           one RGBA pixel
//   cfg      cfg_valid cfg_ready cfg_index cfg_data register write
//
// One item per cycle in 8, 16 and 24 bpp while the output does not stall;
// a 4bpp byte giving two pixels holds the decode stage until both are out,
// as the output port moves one pixel a cycle. An accepted item goes into
// the decode stage as the palette RAM is read, then into the output register
// that drives out_valid. Reset is synchronous; palette valid bits clear at
// once, so there is no clearing pass. A stalled output holds the decode
// stage and then the input; cfg is always ready.
// ----------------------------------------------------------------------------
module tim_pixel_decoder_to_rgba_core #(
  parameter int MAX_WIDTH     = 1024,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tpd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int BW = $clog2(3 * MAX_WIDTH + 2);
  localparam int RW = BW + 1;
  localparam int CW = (WW > 11) ? WW : 11;
  localparam int AW = $clog2(PALETTE_DEPTH);

  // configuration
  tpd_pkg::pix_mode_t cfg_mode_r;
  logic [10:0]        cfg_width_r;
  logic [9:0]         cfg_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_mode_r   <= tpd_pkg::MODE_16BPP;
      cfg_width_r  <= 11'd1;
      cfg_height_r <= 10'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        tpd_pkg::CFG_PIXEL_MODE:   cfg_mode_r   <= tpd_pkg::pix_mode_t'(cfg_data[1:0]);
        tpd_pkg::CFG_IMAGE_WIDTH:  cfg_width_r  <= cfg_data;
        tpd_pkg::CFG_IMAGE_HEIGHT: cfg_height_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [CW-1:0] wreg;
  logic [WW-1:0] w;
  logic [9:0]    h;
  logic [RW-1:0] wl;
  logic [RW-1:0] row_len;

  assign wreg = CW'(cfg_width_r);

  always_comb begin
    if (wreg == '0) begin
      w = WW'(1);
    end else if (wreg > CW'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = wreg[WW-1:0];
    end
    if (cfg_height_r == 10'd0) begin
      h = 10'd1;
    end else if (cfg_height_r > 10'(tpd_pkg::MAX_HEIGHT)) begin
      h = 10'(tpd_pkg::MAX_HEIGHT);
    end else begin
      h = cfg_height_r;
    end
  end

  assign wl = RW'(w);

  always_comb begin
    case (cfg_mode_r)
      tpd_pkg::MODE_4BPP:  row_len = ((wl + RW'(3)) >> 2) << 1;
      tpd_pkg::MODE_8BPP:  row_len = (wl + RW'(1)) & ~RW'(1);
      tpd_pkg::MODE_16BPP: row_len = wl << 1;
      default:             row_len = (wl * RW'(3) + RW'(1)) & ~RW'(1);
    endcase
  end

  // stream state
  logic [BW-1:0] byte_r, byte_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [WW-1:0] pix_r, pix_nxt;
  logic [8:0]    row_r, row_nxt;
  logic [15:0]   held_r, held_nxt;
  logic [PALETTE_DEPTH-1:0] pvalid_r;

  // decode stage
  logic                s1_valid_r;
  logic                s1_two_r;
  logic                s1_sel_r;
  logic                s1_ram_r;
  logic                s1_eoi0_r, s1_eoi1_r;
  logic                s1_zero0_r, s1_zero1_r;
  tpd_pkg::out_item_t  s1_direct_r;

  // output register
  logic                out_valid_r;
  tpd_pkg::out_item_t  out_data_r;

  logic out_free, s1_done, in_acc, is_data, pal_we;
  assign out_free = !out_valid_r || out_ready;
  assign s1_done  = s1_valid_r && out_free && (s1_sel_r || !s1_two_r);
  assign in_ready = !s1_valid_r || s1_done;
  assign in_acc   = in_valid && in_ready;
  assign is_data  = (in_data.command == tpd_pkg::CMD_DATA);

  logic [8:0] pal_idx_ext;
  assign pal_idx_ext = {1'b0, in_data.palette_index};
  assign pal_we      = in_acc && !is_data && (pal_idx_ext < 9'(PALETTE_DEPTH));

  // pixel decisions for the current byte
  logic [7:0]    d;
  logic [WW:0]   p1, p2, wx;
  logic          row_last, below_w, emit0, emit1, eoi0, eoi1;
  logic [1:0]    npix;
  logic [RW-1:0] byte_inc;
  logic          wrap;
  logic [9:0]    row_inc;
  logic [AW-1:0] raddr_a, raddr_b;
  logic          d_in_range, zero0, zero1;
  tpd_pkg::out_item_t direct_pix;

  assign d        = in_data.data_byte;
  assign wx       = {1'b0, w};
  assign p1       = {1'b0, pix_r} + (WW+1)'(1);
  assign p2       = {1'b0, pix_r} + (WW+1)'(2);
  assign row_last = ({1'b0, row_r} + 10'd1) == h;
  assign below_w  = pix_r < w;
  assign eoi0     = (p1 == wx) && row_last;
  assign eoi1     = (p2 == wx) && row_last;

  always_comb begin
    emit1 = 1'b0;
    case (cfg_mode_r)
      tpd_pkg::MODE_4BPP: begin
        emit0 = below_w;
        emit1 = below_w && (p1 < wx);
      end
      tpd_pkg::MODE_8BPP:  emit0 = below_w;
      tpd_pkg::MODE_16BPP: emit0 = byte_r[0] && below_w;
      default:             emit0 = (phase_r == 2'd2) && below_w;
    endcase
    npix = {1'b0, emit0} + {1'b0, emit1};
  end

  assign raddr_a    = (cfg_mode_r == tpd_pkg::MODE_4BPP) ? AW'(d[3:0]) : AW'(d);
  assign raddr_b    = AW'(d[7:4]);
  assign d_in_range = {1'b0, d} < 9'(PALETTE_DEPTH);
  assign zero0      = (cfg_mode_r == tpd_pkg::MODE_4BPP) ? !pvalid_r[raddr_a] :
                      (d_in_range ? !pvalid_r[raddr_a] : 1'b1);
  assign zero1      = !pvalid_r[raddr_b];

  always_comb begin
    if (cfg_mode_r == tpd_pkg::MODE_16BPP) begin
      direct_pix = tpd_pkg::bgr555_pixel({d, held_r[7:0]});
    end else begin
      direct_pix.red          = held_r[7:0];
      direct_pix.green        = held_r[15:8];
      direct_pix.blue         = d;
      direct_pix.alpha        = tpd_pkg::ALPHA_OPAQUE;
      direct_pix.last_of_run  = 1'b0;
      direct_pix.end_of_image = 1'b0;
    end
  end

  assign byte_inc = RW'(byte_r) + RW'(1);
  assign wrap     = byte_inc >= row_len;
  assign row_inc  = {1'b0, row_r} + 10'd1;

  always_comb begin
    byte_nxt  = byte_r;
    phase_nxt = phase_r;
    pix_nxt   = pix_r;
    row_nxt   = row_r;
    held_nxt  = held_r;
    if (in_acc && is_data) begin
      case (cfg_mode_r)
        tpd_pkg::MODE_16BPP: begin
          if (!byte_r[0]) begin
            held_nxt = {8'd0, d};
          end
        end
        tpd_pkg::MODE_24BPP: begin
          if (phase_r == 2'd0) begin
            held_nxt = {8'd0, d};
          end else if (phase_r == 2'd1) begin
            held_nxt = {d, held_r[7:0]};
          end
        end
        default: ;
      endcase
      if (wrap) begin
        byte_nxt  = '0;
        phase_nxt = 2'd0;
        pix_nxt   = '0;
        row_nxt   = (row_inc >= h) ? 9'd0 : row_inc[8:0];
      end else begin
        byte_nxt  = byte_inc[BW-1:0];
        phase_nxt = (phase_r == 2'd2) ? 2'd0 : phase_r + 2'd1;
        pix_nxt   = pix_r + WW'(npix);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r   <= '0;
      phase_r  <= 2'd0;
      pix_r    <= '0;
      row_r    <= 9'd0;
      held_r   <= 16'd0;
      pvalid_r <= '0;
    end else begin
      byte_r  <= byte_nxt;
      phase_r <= phase_nxt;
      pix_r   <= pix_nxt;
      row_r   <= row_nxt;
      held_r  <= held_nxt;
      if (pal_we) begin
        pvalid_r[in_data.palette_index[AW-1:0]] <= 1'b1;
      end
    end
  end

  // palette
  logic [15:0] rd_a, rd_b;

  tpd_ram #(
    .WIDTH (16),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .we      (pal_we),
    .waddr   (in_data.palette_index[AW-1:0]),
    .wdata   (in_data.palette_word),
    .re      (in_acc && is_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // decode stage
  logic s1_load;
  assign s1_load = in_acc && is_data && (npix != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_sel_r   <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
      s1_sel_r   <= 1'b0;
    end else if (s1_done) begin
      s1_valid_r <= 1'b0;
      s1_sel_r   <= 1'b0;
    end else if (s1_valid_r && out_free) begin
      s1_sel_r   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_two_r    <= emit1;
      s1_ram_r    <= (cfg_mode_r == tpd_pkg::MODE_4BPP) ||
                     (cfg_mode_r == tpd_pkg::MODE_8BPP);
      s1_eoi0_r   <= eoi0;
      s1_eoi1_r   <= eoi1;
      s1_zero0_r  <= zero0;
      s1_zero1_r  <= zero1;
      s1_direct_r <= direct_pix;
    end
  end

  logic [15:0]        s1_word;
  tpd_pkg::out_item_t s1_pix;

  always_comb begin
    if (s1_sel_r) begin
      s1_word = s1_zero1_r ? 16'd0 : rd_b;
    end else begin
      s1_word = s1_zero0_r ? 16'd0 : rd_a;
    end
    s1_pix              = s1_ram_r ? tpd_pkg::bgr555_pixel(s1_word) : s1_direct_r;
    s1_pix.last_of_run  = s1_sel_r || !s1_two_r;
    s1_pix.end_of_image = s1_sel_r ? s1_eoi1_r : s1_eoi0_r;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_data_r <= s1_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_two_only_indexed: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_two_r |-> s1_ram_r)
    else $error("two-pixel item from a direct mode");

  a_sel_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_sel_r |-> s1_two_r)
    else $error("second pixel selected on a single-pixel item");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |-> !in_ready)
    else $error("input taken while decode stage is blocked");

  a_load_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_load |=> s1_valid_r && !s1_sel_r)
    else $error("decoded item lost");

endmodule

### bench/tim_pixel_decoder_to_rgba_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tim_pixel_decoder_to_rgba_core_tb
// Self-checking bench for the TIM pixel decoder. A clocked driver feeds
// palette writes, image bytes and register writes from a job queue. Every
// accepted item is decoded by a local model of the palette, row counters
// and pixel modes into the pixels it should give. A clocked monitor then
// compares each output pixel, field by field, with the oldest one due.
// Register writes go in only once the decoder has drained. Both channels
// stall at random, with one stretch kept free of stalls.
// ----------------------------------------------------------------------------
module tim_pixel_decoder_to_rgba_core_tb;

  localparam int MAX_WIDTH    = 1024;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE_GAP   = 8;
  localparam int END_GAP      = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    JOB_ITEM,
    JOB_REG,
    JOB_SETTLE
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    tpd_pkg::in_item_t  item;
    logic [1:0]         reg_idx;
    logic [10:0]        reg_val;
    logic               calm;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  tpd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tpd_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [10:0] cfg_data = '0;

  job_t pending[$];
  tpd_pkg::out_item_t pixels_due[$];
  int failures = 0;
  int cycles = 0;
  int settle_left = 0;
  logic calm_now = 1'b0;

  // decoder model state
  logic [15:0] palette_mem [256] = '{default: 16'h0000};
  tpd_pkg::pix_mode_t cur_mode = tpd_pkg::MODE_16BPP;
  logic [10:0] cur_width = 11'd1;
  logic [9:0] cur_height = 10'd1;
  logic [11:0] row_byte = '0;
  logic [10:0] row_pixel = '0;
  logic [9:0] row_no = '0;
  logic [15:0] held = '0;

  // stimulus-side view of the settings
  tpd_pkg::pix_mode_t gen_mode = tpd_pkg::MODE_16BPP;
  logic [10:0] gen_width = 11'd1;
  logic [9:0] gen_height = 10'd1;
  logic gen_calm = 1'b0;
  int gen_items = 0;

  tim_pixel_decoder_to_rgba_core #(
    .MAX_WIDTH(MAX_WIDTH),
    .PALETTE_DEPTH(256)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int clamp_width(logic [10:0] v);
    if (v == 11'd0) return 1;
    if (v > 11'(MAX_WIDTH)) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int clamp_height(logic [9:0] v);
    if (v == 10'd0) return 1;
    if (v > 10'(tpd_pkg::MAX_HEIGHT)) return tpd_pkg::MAX_HEIGHT;
    return int'(v);
  endfunction

  // padded bytes per row
  function automatic int padded_row_len(tpd_pkg::pix_mode_t m, int w);
    case (m)
      tpd_pkg::MODE_4BPP:  return ((w + 3) / 4) * 2;
      tpd_pkg::MODE_8BPP:  return ((w + 1) / 2) * 2;
      tpd_pkg::MODE_16BPP: return w * 2;
      default:             return ((w * 3 + 1) / 2) * 2;
    endcase
  endfunction

  function automatic logic [7:0] grow5(logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic tpd_pkg::out_item_t colour_of(logic [15:0] c);
    tpd_pkg::out_item_t p;
    p.red          = grow5(c[4:0]);
    p.green        = grow5(c[9:5]);
    p.blue         = grow5(c[14:10]);
    p.alpha        = c[15] ? tpd_pkg::ALPHA_OPAQUE : 8'd0;
    p.last_of_run  = 1'b0;
    p.end_of_image = 1'b0;
    return p;
  endfunction

  function automatic void close_pixel(inout tpd_pkg::out_item_t p, input int w, input int h);
    p.end_of_image = (int'(row_pixel) + 1 == w) && (int'(row_no) + 1 == h);
    row_pixel++;
  endfunction

  function automatic void decode_item(tpd_pkg::in_item_t it);
    int w;
    int h;
    int n;
    tpd_pkg::out_item_t px [2];
    logic [7:0] d;
    w = clamp_width(cur_width);
    h = clamp_height(cur_height);
    d = it.data_byte;
    n = 0;
    if (it.command == tpd_pkg::CMD_PALETTE) begin
      palette_mem[it.palette_index] = it.palette_word;
      return;
    end
    case (cur_mode)
      tpd_pkg::MODE_4BPP: begin
        if (int'(row_pixel) < w) begin
          px[n] = colour_of(palette_mem[d[3:0]]);
          close_pixel(px[n], w, h);
          n++;
        end
        if (int'(row_pixel) < w) begin
          px[n] = colour_of(palette_mem[d[7:4]]);
          close_pixel(px[n], w, h);
          n++;
        end
      end
      tpd_pkg::MODE_8BPP: begin
        if (int'(row_pixel) < w) begin
          px[0] = colour_of(palette_mem[d]);
          close_pixel(px[0], w, h);
          n = 1;
        end
      end
      tpd_pkg::MODE_16BPP: begin
        if (!row_byte[0]) begin
          held = {8'h00, d};
        end else if (int'(row_pixel) < w) begin
          px[0] = colour_of({d, held[7:0]});
          close_pixel(px[0], w, h);
          n = 1;
        end
      end
      default: begin
        if (row_byte % 3 == 0) begin
          held = {8'h00, d};
        end else if (row_byte % 3 == 1) begin
          held[15:8] = d;
        end else if (int'(row_pixel) < w) begin
          px[0] = '{red: held[7:0], green: held[15:8], blue: d,
                    alpha: tpd_pkg::ALPHA_OPAQUE,
                    last_of_run: 1'b0, end_of_image: 1'b0};
          close_pixel(px[0], w, h);
          n = 1;
        end
      end
    endcase
    if (n > 0) px[n - 1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) pixels_due.push_back(px[i]);
    row_byte++;
    if (int'(row_byte) >= padded_row_len(cur_mode, w)) begin
      row_byte = '0;
      row_pixel = '0;
      row_no++;
      if (int'(row_no) >= h) row_no = '0;
    end
  endfunction

  function automatic void write_reg(logic [1:0] idx, logic [10:0] val);
    case (idx)
      tpd_pkg::CFG_PIXEL_MODE:   cur_mode = tpd_pkg::pix_mode_t'(val[1:0]);
      tpd_pkg::CFG_IMAGE_WIDTH:  cur_width = val;
      tpd_pkg::CFG_IMAGE_HEIGHT: cur_height = val[9:0];
      default: ;
    endcase
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    job_t j;
    j = '0;
    j.kind = JOB_ITEM;
    j.calm = gen_calm;
    j.item.command = tpd_pkg::CMD_DATA;
    j.item.palette_index = 8'($urandom);
    j.item.palette_word = 16'($urandom);
    j.item.data_byte = b;
    pending.push_back(j);
    gen_items++;
  endfunction

  function automatic void queue_palette(logic [7:0] idx, logic [15:0] word);
    job_t j;
    j = '0;
    j.kind = JOB_ITEM;
    j.calm = gen_calm;
    j.item.command = tpd_pkg::CMD_PALETTE;
    j.item.palette_index = idx;
    j.item.palette_word = word;
    j.item.data_byte = 8'($urandom);
    pending.push_back(j);
    gen_items++;
  endfunction

  // registers change only once the decoder has drained
  function automatic void queue_reg(logic [1:0] idx, logic [10:0] val);
    job_t j;
    j = '0;
    j.kind = JOB_SETTLE;
    pending.push_back(j);
    j.kind = JOB_REG;
    j.reg_idx = idx;
    j.reg_val = val;
    pending.push_back(j);
    if (idx == tpd_pkg::CFG_PIXEL_MODE) gen_mode = tpd_pkg::pix_mode_t'(val[1:0]);
    else if (idx == tpd_pkg::CFG_IMAGE_WIDTH) gen_width = val;
    else if (idx == tpd_pkg::CFG_IMAGE_HEIGHT) gen_height = val[9:0];
  endfunction

  function automatic void queue_rows(int rows);
    int n;
    n = rows * padded_row_len(gen_mode, clamp_width(gen_width));
    repeat (n) begin
      if ($urandom_range(0, 19) == 0)
        queue_palette(8'($urandom_range(0, 15)), 16'($urandom));
      queue_byte(8'($urandom));
    end
  endfunction

  task automatic check_pixel_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      failures++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    logic next_in;
    logic next_cfg;
    job_t job;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      next_in = in_valid && !in_ready;
      next_cfg = cfg_valid && !cfg_ready;
      if (in_valid && in_ready) decode_item(in_data);
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (next_in || next_cfg) begin
      end else if (settle_left > 0) begin
        settle_left--;
      end else if (pending.size() > 0) begin
        job = pending[0];
        case (job.kind)
          JOB_ITEM: begin
            if (job.calm || $urandom_range(0, 99) >= 19) begin
              in_data <= job.item;
              calm_now <= job.calm;
              next_in = 1'b1;
              void'(pending.pop_front());
            end
          end
          JOB_REG: begin
            cfg_index <= job.reg_idx;
            cfg_data <= job.reg_val;
            next_cfg = 1'b1;
            void'(pending.pop_front());
          end
          default: begin
            if (pixels_due.size() == 0) begin
              settle_left = SETTLE_GAP;
              void'(pending.pop_front());
            end
          end
        endcase
      end
      in_valid <= next_in;
      cfg_valid <= next_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    tpd_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected pixel, expected none got %h", $time, out_data);
          failures++;
        end else begin
          want = pixels_due.pop_front();
          check_pixel_field("red", int'(want.red), int'(out_data.red));
          check_pixel_field("green", int'(want.green), int'(out_data.green));
          check_pixel_field("blue", int'(want.blue), int'(out_data.blue));
          check_pixel_field("alpha", int'(want.alpha), int'(out_data.alpha));
          check_pixel_field("last_of_run", int'(want.last_of_run),
                            int'(out_data.last_of_run));
          check_pixel_field("end_of_image", int'(want.end_of_image),
                            int'(out_data.end_of_image));
        end
      end
      out_ready <= calm_now || ($urandom_range(0, 99) >= 19);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int first_random;
    int phase;
    int hgt;
    int rows;

    // reset settings: 16bpp, one pixel per image
    queue_byte(8'h00);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'hFF);
    queue_palette(8'd0, 16'hFFFF);
    queue_palette(8'd255, 16'h8000);
    queue_palette(8'd15, 16'h7FFF);
    queue_palette(8'd1, 16'h001F);

    // 4bpp odd width: second byte of a row gives a single pixel
    queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'(tpd_pkg::MODE_4BPP));
    queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd3);
    queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd2);
    queue_byte(8'hF0);
    queue_byte(8'h1F);
    queue_byte(8'h10);
    queue_byte(8'hF1);

    // 8bpp with a padding byte
    queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'(tpd_pkg::MODE_8BPP));
    queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd1);
    queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd1);
    queue_byte(8'hFF);
    queue_byte(8'h00);

    // 24bpp, widest row then narrowed mid-row
    queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'(tpd_pkg::MODE_24BPP));
    queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd2047);
    repeat (5) queue_byte(8'($urandom));
    queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd0);
    queue_byte(8'h5A);

    // height extremes
    queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'(tpd_pkg::MODE_16BPP));
    queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd0);
    queue_byte(8'h34);
    queue_byte(8'h92);
    queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd1023);
    queue_reg(CFG_SPARE, 11'd2047);
    queue_byte(8'hC3);
    queue_byte(8'h6D);

    first_random = gen_items;
    phase = 0;
    while (gen_items < first_random + RANDOM_ITEMS) begin
      phase++;
      gen_calm = (phase >= 6 && phase < 11);
      if (phase == 5) begin
        // clamped width, row left unfinished, then back to a narrow row
        queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'(tpd_pkg::MODE_4BPP));
        queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd2047);
        queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd1);
        repeat (40) queue_byte(8'($urandom));
        queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(1, 10)));
        continue;
      end
      if ($urandom_range(0, 2) != 0) queue_reg(tpd_pkg::CFG_PIXEL_MODE, 11'($urandom));
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 19))
          0: queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'd0);
          1: queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(11, 48)));
          default: queue_reg(tpd_pkg::CFG_IMAGE_WIDTH, 11'($urandom_range(1, 10)));
        endcase
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 11))
          0: queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd0);
          1: queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd1024);
          2: queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd1023);
          3: queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'd2047);
          default: queue_reg(tpd_pkg::CFG_IMAGE_HEIGHT, 11'($urandom_range(1, 3)));
        endcase
      end
      if ($urandom_range(0, 15) == 0) queue_reg(CFG_SPARE, 11'($urandom));
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 1) != 0) queue_palette(8'($urandom_range(0, 15)), 16'($urandom));
        else queue_palette(8'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 9) == 0) begin
        // broken row: one to seven bytes, which may leave the counters mid-row
        repeat ($urandom_range(1, 7)) queue_byte(8'($urandom));
      end else begin
        hgt = clamp_height(gen_height);
        rows = (hgt <= 3) ? hgt * int'($urandom_range(1, 2)) : int'($urandom_range(1, 3));
        queue_rows(rows);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending.size() != 0 || in_valid || cfg_valid || pixels_due.size() != 0)
      @(posedge clk);
    repeat (END_GAP) @(posedge clk);
    if (failures == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

### tim_pixel_decoder_to_rgba_core.f
sv/tpd_pkg.sv
sv/tpd_ram.sv
sv/tim_pixel_decoder_to_rgba_core.sv
bench/tim_pixel_decoder_to_rgba_core_tb.sv
